// File: hdl/phm_pkg.sv
// Shared types and constants for the peak hold level meter.
`default_nettype none
package phm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 17;
	localparam int COEF_W   = 16;
	localparam int TICKS_W  = 10;
	localparam int HOLD_W   = 12;
	localparam int OUT_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [LEVEL_W-1:0]   FULL_SCALE = 17'h0_8000;
	localparam logic [COEF_W-1:0]    DECAY_RST  = 16'd55706;
	localparam logic [TICKS_W-1:0]   HOLD_RST   = 10'd40;

	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COEF = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 1'b1;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_TICK   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef struct packed {
		logic [COEF_W-1:0]  decay_coef;
		logic [TICKS_W-1:0] hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic [OUT_W-1:0] shown_level;
		logic [OUT_W-1:0] held_peak;
		logic [OUT_W-1:0] max_since_reset;
		logic             clipped;
	} res_t;

endpackage
`default_nettype wire

// File: hdl/phm_in_if.sv
// Input channel: operation and audio sample with valid/ready handshake.
`default_nettype none
interface phm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic signed [15:0] sample_value;

	modport source (output valid, output operation, output sample_value, input ready);
	modport sink (input valid, input operation, input sample_value, output ready);
endinterface
`default_nettype wire

// File: hdl/phm_out_if.sv
// Output channel: meter readings with valid/ready handshake.
`default_nettype none
interface phm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] shown_level;
	logic [15:0] held_peak;
	logic [15:0] max_since_reset;
	logic        clipped;

	modport source (output valid, output shown_level, output held_peak,
		output max_since_reset, output clipped, input ready);
	modport sink (input valid, input shown_level, input held_peak,
		input max_since_reset, input clipped, output ready);
endinterface
`default_nettype wire

// File: hdl/peak_hold_level_meter.sv
// Top level of the peak hold level meter: input stage, state update, result register.
// An input transaction passes the input register and then the result register before result valid.
// Throughput: one transaction per cycle while the output channel does not stall.
// The input stage keeps accepting while a result waits, until both registers are full.
// Reset: arst_n clears all meter state, the handshake registers and loads the
// default decay coefficient and hold length.
`default_nettype none
module peak_hold_level_meter
	import phm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	phm_in_if.sink                     in_ch,
	phm_out_if.source                  out_ch
);

	cfg_t cfg;
	res_t res_d;
	res_t res_q;

	logic                       valid_s1;
	logic [1:0]                 operation_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       out_valid_q;
	logic                       adv;

	phm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign adv          = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.ready)
			valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			operation_s1 <= in_ch.operation;
			sample_s1    <= in_ch.sample_value;
		end
	end

	phm_state u_state (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.operation    (operation_s1),
		.sample_value (sample_s1),
		.cfg          (cfg),
		.res_d        (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_d;
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.shown_level     = res_q.shown_level;
	assign out_ch.held_peak       = res_q.held_peak;
	assign out_ch.max_since_reset = res_q.max_since_reset;
	assign out_ch.clipped         = res_q.clipped;

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ch.ready |=> valid_s1)
		else $error("input stage lost a transaction during an output stall");

	a_ready_only_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> valid_s1 && out_valid_q)
		else $error("input stalled with room in the pipeline");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && operation_s1 == OP_CLEAR |=>
		out_ch.valid && !out_ch.clipped && out_ch.max_since_reset == '0
		&& out_ch.held_peak == '0)
		else $error("clear did not zero the peaks");

	a_adv_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("result register not marked valid after update");

endmodule
`default_nettype wire

// File: hdl/phm_cfg.sv
// Configuration registers of the level meter.
`default_nettype none
module phm_cfg
	import phm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	logic [COEF_W-1:0]  decay_coef_q;
	logic [TICKS_W-1:0] hold_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_coef_q <= DECAY_RST;
			hold_ticks_q <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DECAY_COEF: decay_coef_q <= cfg_wdata[COEF_W-1:0];
				CFG_HOLD_TICKS: hold_ticks_q <= cfg_wdata[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.decay_coef = decay_coef_q;
	assign cfg.hold_ticks = hold_ticks_q;

endmodule
`default_nettype wire

// File: hdl/phm_state.sv
// Meter state registers and the per-transaction update logic.
`default_nettype none
module phm_state
	import phm_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic [1:0]                 operation,
	input  wire logic signed [SAMPLE_W-1:0] sample_value,
	input  wire cfg_t                       cfg,
	output res_t                            res_d
);

	logic [LEVEL_W-1:0]       level_q, snap_q, peak_q, max_q;
	logic signed [HOLD_W-1:0] hold_q;
	logic                     clip_q;

	logic [LEVEL_W-1:0]       level_d, snap_d, peak_d, max_d;
	logic signed [HOLD_W-1:0] hold_d;
	logic                     clip_d;

	logic [LEVEL_W-1:0]          mag;
	logic [LEVEL_W-1:0]          raised;
	logic [LEVEL_W+COEF_W-1:0]   product;

	always_comb begin
		if (sample_value[SAMPLE_W-1])
			mag = LEVEL_W'(17'h1_0000 - {1'b0, sample_value});
		else
			mag = {1'b0, sample_value};
		raised  = (level_q < mag) ? mag : level_q;
		product = level_q * cfg.decay_coef;
	end

	always_comb begin
		level_d = level_q;
		snap_d  = snap_q;
		peak_d  = peak_q;
		max_d   = max_q;
		hold_d  = hold_q;
		clip_d  = clip_q;
		case (op_t'(operation))
			OP_SAMPLE: begin
				level_d = raised;
				if (peak_q < raised || hold_q[HOLD_W-1]) begin
					peak_d = raised;
					hold_d = HOLD_W'({1'b0, cfg.hold_ticks});
				end
			end
			OP_TICK: begin
				snap_d  = level_q;
				level_d = product[LEVEL_W+COEF_W-1:COEF_W];
				if (!hold_q[HOLD_W-1])
					hold_d = hold_q - HOLD_W'(1);
				if (max_q < peak_q) begin
					max_d = peak_q;
					if (peak_q >= FULL_SCALE)
						clip_d = 1'b1;
				end
			end
			OP_CLEAR: begin
				level_d = '0;
				peak_d  = '0;
				max_d   = '0;
				clip_d  = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			snap_q  <= '0;
			peak_q  <= '0;
			max_q   <= '0;
			hold_q  <= '0;
			clip_q  <= 1'b0;
		end else if (en) begin
			level_q <= level_d;
			snap_q  <= snap_d;
			peak_q  <= peak_d;
			max_q   <= max_d;
			hold_q  <= hold_d;
			clip_q  <= clip_d;
		end
	end

	assign res_d.shown_level     = snap_d[OUT_W-1:0];
	assign res_d.held_peak       = peak_d[OUT_W-1:0];
	assign res_d.max_since_reset = max_d[OUT_W-1:0];
	assign res_d.clipped         = clip_d;

endmodule
`default_nettype wire
